@@ rtl/core/mas_pkg.sv @@
// Package for the multichannel ADC moving-sum block.
// Holds field widths, register index codes and the item record between stages.
// No dependencies.
package mas_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W = 15;
  localparam int HEAD_W = 5;
  localparam int SEL_W = 3;
  localparam int EN_W = 8;
  localparam int LEN_FIELD_W = 6;
  localparam int LENS_W = 48;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNEL_ENABLE = 1'b0,
    REG_WINDOW_LENGTHS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SEL_W-1:0]    channel;
    logic                on;
    logic [HEAD_W-1:0]   head;
    logic [SAMPLE_W-1:0] sample;
  } issue_t;

endpackage

@@ rtl/core/mas_if.sv @@
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on mas_pkg for field widths.
interface mas_sample_if;
  logic                          valid;
  logic                          ready;
  logic [mas_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mas_result_if;
  logic                          valid;
  logic                          ready;
  logic [mas_pkg::SEL_W-1:0]     channel;
  logic [mas_pkg::SUM_W-1:0]     window_sum;
  logic [mas_pkg::HEAD_W-1:0]    head;
  logic                          updated;
  modport source (output valid, output channel, output window_sum, output head,
                  output updated, input ready);
  modport sink (input valid, input channel, input window_sum, input head,
                input updated, output ready);
endinterface

interface mas_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mas_pkg::CFG_INDEX_W-1:0] index;
  logic [mas_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/multichannel_adc_moving_sum_top.sv @@
// Top level of the multichannel ADC moving-sum block: configuration registers and stages.
// Depends on mas_pkg, mas_if, mas_ram, mas_issue and mas_accum.
//
// Each sample beat belongs to the channel the internal selector points at; the selector
// steps 0 to 7 on every beat and wraps after 7. One result beat leaves per sample beat,
// via the s1 and result registers. The block takes one sample per cycle unless the store
// is clearing or results stall: the ring head advance and store read happen on acceptance,
// and the sum update and store write-back as the item leaves s1, on the single-port-pair
// sample store. After reset the store is cleared one entry per cycle over all its
// NUM_CHANNELS * MAX_WINDOW entries, during which no sample is taken; configuration
// writes are taken at any time and should only be made while the block is idle.
module multichannel_adc_moving_sum_top #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_WINDOW = 32
) (
  input  logic         clk,
  input  logic         rst,
  mas_sample_if.sink   samples,
  mas_result_if.source results,
  mas_cfg_if.sink      cfg
);

  localparam int DEPTH = NUM_CHANNELS * MAX_WINDOW;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mas_pkg::EN_W-1:0]     channel_enable;
  logic [mas_pkg::LENS_W-1:0]   window_lengths;
  logic                         accept;
  logic                         busy;
  logic                         can_take;
  mas_pkg::issue_t              info;
  logic [AW-1:0]                rd_addr;
  logic [mas_pkg::SAMPLE_W-1:0] rd_data;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [mas_pkg::SAMPLE_W-1:0] wr_data;

  assign cfg.ready = 1'b1;
  assign samples.ready = !busy && can_take;
  assign accept = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= '0;
      window_lengths <= '0;
    end else if (cfg.valid) begin
      unique case (mas_pkg::reg_index_t'(cfg.index))
        mas_pkg::REG_CHANNEL_ENABLE: channel_enable <= cfg.data[mas_pkg::EN_W-1:0];
        mas_pkg::REG_WINDOW_LENGTHS: window_lengths <= cfg.data[mas_pkg::LENS_W-1:0];
        default: ;
      endcase
    end
  end

  mas_issue #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .MAX_WINDOW(MAX_WINDOW),
    .AW(AW)
  ) u_issue (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .sample(samples.sample),
    .enable(channel_enable),
    .lengths(window_lengths),
    .info(info),
    .addr(rd_addr)
  );

  mas_ram #(
    .DEPTH(DEPTH),
    .AW(AW),
    .DW(mas_pkg::SAMPLE_W)
  ) u_ram (
    .clk(clk),
    .rst(rst),
    .rd_en(accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .busy(busy)
  );

  mas_accum #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .AW(AW)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .info(info),
    .addr(rd_addr),
    .old_sample(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .can_take(can_take),
    .results(results)
  );

endmodule

@@ rtl/core/mas_ram.sv @@
// Sample store: one write port, one registered read port, clearing sweep after reset.
// Depends on nothing but its parameters.
module mas_ram #(
  parameter int DEPTH = 256,
  parameter int AW = 8,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic          busy
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/mas_issue.sv @@
// Issue stage: channel selector, per-channel ring heads and sample store address.
// Depends on mas_pkg.
module mas_issue #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_WINDOW = 32,
  parameter int AW = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [mas_pkg::SAMPLE_W-1:0]    sample,
  input  logic [mas_pkg::EN_W-1:0]        enable,
  input  logic [mas_pkg::LENS_W-1:0]      lengths,
  output mas_pkg::issue_t                 info,
  output logic [AW-1:0]                   addr
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = (HW + 1 > mas_pkg::LEN_FIELD_W) ? HW + 1 : mas_pkg::LEN_FIELD_W;

  logic [mas_pkg::SEL_W-1:0]       sel;
  logic [HW-1:0]                   heads [NUM_CHANNELS];
  logic                            on;
  logic [CH_W-1:0]                 ci;
  logic [mas_pkg::LEN_FIELD_W-1:0] len_field;
  logic [CW-1:0]                   len;
  logic [CW-1:0]                   head_plus;
  logic [CW-1:0]                   nh;

  always_comb begin
    on = (32'(sel) < NUM_CHANNELS) && enable[sel];
    ci = on ? sel[CH_W-1:0] : '0;
    len_field = lengths[mas_pkg::LEN_FIELD_W*sel +: mas_pkg::LEN_FIELD_W];
    len = CW'(len_field);
    if (len == '0) begin
      len = CW'(1);
    end
    if (len > CW'(MAX_WINDOW)) begin
      len = CW'(MAX_WINDOW);
    end
    head_plus = CW'(heads[ci]) + CW'(1);
    nh = (head_plus >= len) ? '0 : head_plus;
    addr = AW'(ci) * AW'(MAX_WINDOW) + AW'(nh);
    info.channel = sel;
    info.on = on;
    info.head = on ? nh[mas_pkg::HEAD_W-1:0] : '0;
    info.sample = sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        heads[i] <= '0;
      end
    end else if (accept) begin
      sel <= sel + 1'b1;
      if (on) begin
        heads[ci] <= nh[HW-1:0];
      end
    end
  end

endmodule

@@ rtl/core/mas_accum.sv @@
// Accumulate stage: running sums, store write-back and the result register.
// Depends on mas_pkg.
module mas_accum #(
  parameter int NUM_CHANNELS = 8,
  parameter int AW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  mas_pkg::issue_t              info,
  input  logic [AW-1:0]                addr,
  input  logic [mas_pkg::SAMPLE_W-1:0] old_sample,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [mas_pkg::SAMPLE_W-1:0] wr_data,
  output logic                         can_take,
  mas_result_if.source                 results
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                        s1_valid;
  mas_pkg::issue_t             s1;
  logic [AW-1:0]               s1_addr;
  logic [mas_pkg::SUM_W-1:0]   sums [NUM_CHANNELS];
  logic [CH_W-1:0]             ci;
  logic [mas_pkg::SUM_W-1:0]   sum_next;
  logic                        advance;

  always_comb begin
    advance = s1_valid && (!results.valid || results.ready);
    can_take = !s1_valid || advance;
    ci = s1.on ? s1.channel[CH_W-1:0] : '0;
    sum_next = sums[ci] - mas_pkg::SUM_W'(old_sample) + mas_pkg::SUM_W'(s1.sample);
    wr_en = advance && s1.on;
    wr_addr = s1_addr;
    wr_data = s1.sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      results.valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        results.valid <= 1'b1;
        if (s1.on) begin
          sums[ci] <= sum_next;
        end
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= info;
      s1_addr <= addr;
    end
    if (advance) begin
      results.channel <= s1.channel;
      results.window_sum <= s1.on ? sum_next : '0;
      results.head <= s1.head;
      results.updated <= s1.on;
    end
  end

endmodule
